// ===== sv/frm_pkg.sv =====
// Shared types, constants and codes for the frame rate monitor.
`default_nettype none

package frm_pkg;

   // Default values for the top-level parameters.
   localparam int STAMP_BITS_DEF     = 48;
   localparam int MULT_FRAC_BITS_DEF = 14;
   localparam int RATE_FRAC_BITS_DEF = 8;

   // Fixed field widths.
   localparam int KIND_W     = 2;
   localparam int TPF_W      = 24;
   localparam int TPS_W      = 32;
   localparam int INTV_W     = 32;
   localparam int CNT_W      = 24;
   localparam int TOTAL_W    = 32;
   localparam int RATE_W     = 24;
   localparam int MULT_OUT_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUSPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESUME  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_STEP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_FRAME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_SECOND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_INTERVAL = 3'd4;

   // Register reset values.
   localparam logic [TPF_W-1:0]  TPF_RESET      = 24'd16667;
   localparam logic [TPS_W-1:0]  TPS_RESET      = 32'd1000000;
   localparam logic [INTV_W-1:0] AVG_INT_RESET  = 32'd1000000;
   localparam logic [INTV_W-1:0] LOG_INT_RESET  = 32'd5000000;

   typedef struct packed {
      logic              fixed_step;
      logic [TPF_W-1:0]  ticks_frame;
      logic [TPS_W-1:0]  ticks_second;
      logic [INTV_W-1:0] avg_interval;
      logic [INTV_W-1:0] log_interval;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SHIFT,
      ST_TERM_START,
      ST_TERM_WAIT,
      ST_CHECK_AVG,
      ST_CHECK_LOG,
      ST_RATE_START,
      ST_RATE_WAIT,
      ST_DONE
   } fsm_state_type;

endpackage

`default_nettype wire

// ===== sv/frame_rate_monitor.sv =====
// Top level of the frame rate monitor: sequencer, timing state and result register.
`default_nettype none

// Frame timing monitor. Each request carries an event kind (frame end, suspend or
// resume) and a free-running tick stamp, and yields one result. The block takes one
// request at a time and holds req_stall high until the result sits in the output
// register. A suspend passes through the evaluate and done states, a resume through
// the shift state as well. A frame end runs one shared divider that produces one
// quotient bit per cycle: 24 steps for the time multiplier and 24 more for a rate
// update when the averaging or else the logging interval has run out, with one
// multiplier feeding it.
module frame_rate_monitor #(
   parameter int STAMP_BITS     = frm_pkg::STAMP_BITS_DEF,
   parameter int MULT_FRAC_BITS = frm_pkg::MULT_FRAC_BITS_DEF,
   parameter int RATE_FRAC_BITS = frm_pkg::RATE_FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [frm_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [STAMP_BITS-1:0]          req_stamp,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [frm_pkg::MULT_OUT_W-1:0]      rsp_time_mult,
   output logic [STAMP_BITS-1:0]               rsp_frame_len,
   output logic [frm_pkg::RATE_W-1:0]          rsp_avg_rate,
   output logic [frm_pkg::TOTAL_W-1:0]         rsp_frame_total,
   output logic [STAMP_BITS-1:0]               rsp_paused_len,
   output logic                                rsp_time_jump,
   input  wire logic                           csr_wr_en,
   input  wire logic [frm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import frm_pkg::*;

   localparam int HW     = MULT_FRAC_BITS + 2;
   localparam int SUM_W  = HW + 2;
   localparam int LIM_W  = TPF_W + 1;
   localparam int PROD_W = CNT_W + TPS_W;
   localparam int NUM_W  = PROD_W + RATE_FRAC_BITS;
   localparam int EXT_W  = HW + MULT_OUT_W;

   cfg_type cfg;

   fsm_state_type state_ff, state_in;

   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [STAMP_BITS-1:0] frame_mark_ff, frame_mark_in;
   logic [STAMP_BITS-1:0] avg_mark_ff, avg_mark_in;
   logic [STAMP_BITS-1:0] log_mark_ff, log_mark_in;
   logic [STAMP_BITS-1:0] pause_mark_ff, pause_mark_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]      avg_cnt_ff, avg_cnt_in;
   logic [CNT_W-1:0]      log_cnt_ff, log_cnt_in;
   logic [HW-1:0]         hist0_ff, hist0_in;
   logic [HW-1:0]         hist1_ff, hist1_in;
   logic [HW-1:0]         hist2_ff, hist2_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [STAMP_BITS-1:0] len_ff, len_in;
   logic [STAMP_BITS-1:0] paused_ff, paused_in;
   logic                  jump_ff, jump_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [STAMP_BITS-1:0] den_ff, den_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MULT_OUT_W-1:0] rsp_mult_ff, rsp_mult_in;
   logic [STAMP_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic [RATE_W-1:0]     rsp_rate_ff, rsp_rate_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic [STAMP_BITS-1:0] rsp_paused_ff, rsp_paused_in;
   logic                  rsp_jump_ff, rsp_jump_in;

   logic                  req_take;
   logic                  out_free;
   logic [TPF_W-1:0]      tpf_eff;
   logic [LIM_W-1:0]      len_limit;
   logic [LIM_W-1:0]      clamped;
   logic [NUM_W-1:0]      term_num;
   logic [NUM_W-1:0]      rate_num;
   logic                  div_start;
   logic [NUM_W-1:0]      div_num;
   logic [STAMP_BITS-1:0] div_den;
   logic                  div_done;
   logic [RATE_W-1:0]     div_quot;
   logic [SUM_W-1:0]      hist_sum;
   logic [STAMP_BITS-1:0] elapsed_avg;
   logic [STAMP_BITS-1:0] elapsed_log;
   logic [CNT_W-1:0]      mul_cnt;
   logic [PROD_W-1:0]     product;
   logic [EXT_W-1:0]      mult_ext;

   frm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   frm_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (STAMP_BITS),
      .QUOT_W (RATE_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // A zero nominal length divides as one.
   assign tpf_eff   = (cfg.ticks_frame == '0) ? TPF_W'(1) : cfg.ticks_frame;
   assign len_limit = {tpf_eff, 1'b0};
   assign clamped   = (len_ff < STAMP_BITS'(len_limit)) ? LIM_W'(len_ff) : len_limit;
   assign term_num  = NUM_W'(clamped) << MULT_FRAC_BITS;
   assign rate_num  = NUM_W'(prod_ff) << RATE_FRAC_BITS;

   assign div_start = (state_ff == ST_TERM_START) || (state_ff == ST_RATE_START);
   assign div_num   = (state_ff == ST_TERM_START) ? term_num : rate_num;
   assign div_den   = (state_ff == ST_TERM_START) ? STAMP_BITS'(tpf_eff) : den_ff;

   assign hist_sum  = SUM_W'(hist0_ff) + SUM_W'(hist1_ff) + SUM_W'(hist2_ff)
                    + SUM_W'(div_quot[HW-1:0]);

   assign elapsed_avg = stamp_ff - avg_mark_ff;
   assign elapsed_log = stamp_ff - log_mark_ff;

   assign mul_cnt = (state_ff == ST_CHECK_AVG) ? avg_cnt_ff : log_cnt_ff;
   assign product = PROD_W'(mul_cnt) * PROD_W'(cfg.ticks_second);

   assign mult_ext = EXT_W'(hist0_ff);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      stamp_in      = stamp_ff;
      frame_mark_in = frame_mark_ff;
      avg_mark_in   = avg_mark_ff;
      log_mark_in   = log_mark_ff;
      pause_mark_in = pause_mark_ff;
      total_in      = total_ff;
      avg_cnt_in    = avg_cnt_ff;
      log_cnt_in    = log_cnt_ff;
      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      hist2_in      = hist2_ff;
      rate_in       = rate_ff;
      len_in        = len_ff;
      paused_in     = paused_ff;
      jump_in       = jump_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_mult_in   = rsp_mult_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_paused_in = rsp_paused_ff;
      rsp_jump_in   = rsp_jump_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in  = req_kind;
               stamp_in = req_stamp;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            len_in    = '0;
            paused_in = '0;
            jump_in   = 1'b0;
            state_in  = ST_DONE;
            if (kind_ff == KIND_FRAME) begin
               if (cfg.fixed_step) begin
                  len_in = STAMP_BITS'(cfg.ticks_frame);
               end else if (stamp_ff >= frame_mark_ff) begin
                  len_in = stamp_ff - frame_mark_ff;
               end
               frame_mark_in = stamp_ff;
               total_in      = total_ff + TOTAL_W'(1);
               avg_cnt_in    = avg_cnt_ff + CNT_W'(1);
               log_cnt_in    = log_cnt_ff + CNT_W'(1);
               // A stamp behind either interval mark restarts both intervals.
               if ((stamp_ff < avg_mark_ff) || (stamp_ff < log_mark_ff)) begin
                  avg_mark_in = stamp_ff;
                  log_mark_in = stamp_ff;
                  jump_in     = 1'b1;
               end
               state_in = ST_TERM_START;
            end else if (kind_ff == KIND_SUSPEND) begin
               pause_mark_in = stamp_ff;
            end else if (kind_ff == KIND_RESUME) begin
               if (stamp_ff >= pause_mark_ff) begin
                  paused_in = stamp_ff - pause_mark_ff;
               end
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            frame_mark_in = frame_mark_ff + paused_ff;
            avg_mark_in   = avg_mark_ff + paused_ff;
            log_mark_in   = log_mark_ff + paused_ff;
            state_in      = ST_DONE;
         end

         ST_TERM_START: begin
            state_in = ST_TERM_WAIT;
         end

         ST_TERM_WAIT: begin
            if (div_done) begin
               hist0_in = hist_sum[SUM_W-1:2];
               hist1_in = hist0_ff;
               hist2_in = hist1_ff;
               state_in = ST_CHECK_AVG;
            end
         end

         ST_CHECK_AVG: begin
            if ((cfg.avg_interval != '0) &&
                (elapsed_avg > STAMP_BITS'(cfg.avg_interval))) begin
               prod_in     = product;
               den_in      = elapsed_avg;
               avg_cnt_in  = '0;
               avg_mark_in = stamp_ff;
               // A rate update here goes straight to the divider and skips the log interval check.
               state_in    = ST_RATE_START;
            end else begin
               state_in = ST_CHECK_LOG;
            end
         end

         ST_CHECK_LOG: begin
            if ((cfg.log_interval != '0) && (avg_cnt_ff != '0) &&
                (elapsed_log > STAMP_BITS'(cfg.log_interval))) begin
               prod_in     = product;
               den_in      = STAMP_BITS'(cfg.log_interval);
               log_cnt_in  = '0;
               log_mark_in = stamp_ff;
               state_in    = ST_RATE_START;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_RATE_START: begin
            state_in = ST_RATE_WAIT;
         end

         ST_RATE_WAIT: begin
            if (div_done) begin
               rate_in  = div_quot;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mult_in   = mult_ext[MULT_OUT_W-1:0];
               rsp_len_in    = len_ff;
               rsp_rate_in   = rate_ff;
               rsp_total_in  = total_ff;
               rsp_paused_in = paused_ff;
               rsp_jump_in   = jump_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
      end else begin
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mark_ff <= '0;
         avg_mark_ff   <= '0;
         log_mark_ff   <= '0;
         pause_mark_ff <= '0;
         total_ff      <= '0;
         avg_cnt_ff    <= '0;
         log_cnt_ff    <= '0;
         hist0_ff      <= HW'(1) << MULT_FRAC_BITS;
         hist1_ff      <= HW'(1) << MULT_FRAC_BITS;
         hist2_ff      <= HW'(1) << MULT_FRAC_BITS;
         rate_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         frame_mark_ff <= frame_mark_in;
         avg_mark_ff   <= avg_mark_in;
         log_mark_ff   <= log_mark_in;
         pause_mark_ff <= pause_mark_in;
         total_ff      <= total_in;
         avg_cnt_ff    <= avg_cnt_in;
         log_cnt_ff    <= log_cnt_in;
         hist0_ff      <= hist0_in;
         hist1_ff      <= hist1_in;
         hist2_ff      <= hist2_in;
         rate_ff       <= rate_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      stamp_ff      <= stamp_in;
      len_ff        <= len_in;
      paused_ff     <= paused_in;
      jump_ff       <= jump_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      rsp_mult_ff   <= rsp_mult_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_paused_ff <= rsp_paused_in;
      rsp_jump_ff   <= rsp_jump_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_time_mult   = rsp_mult_ff;
   assign rsp_frame_len   = rsp_len_ff;
   assign rsp_avg_rate    = rsp_rate_ff;
   assign rsp_frame_total = rsp_total_ff;
   assign rsp_paused_len  = rsp_paused_ff;
   assign rsp_time_jump   = rsp_jump_ff;

endmodule

`default_nettype wire

// ===== sv/frm_csr.sv =====
// Configuration registers of the frame rate monitor.
`default_nettype none

module frm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [frm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output frm_pkg::cfg_type                    cfg
);
   import frm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIXED_STEP:   cfg_in.fixed_step   = csr_wr_data[0];
            CSR_TICKS_FRAME:  cfg_in.ticks_frame  = csr_wr_data[TPF_W-1:0];
            CSR_TICKS_SECOND: cfg_in.ticks_second = csr_wr_data[TPS_W-1:0];
            CSR_AVG_INTERVAL: cfg_in.avg_interval = csr_wr_data[INTV_W-1:0];
            CSR_LOG_INTERVAL: cfg_in.log_interval = csr_wr_data[INTV_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fixed_step   <= 1'b0;
         cfg_ff.ticks_frame  <= TPF_RESET;
         cfg_ff.ticks_second <= TPS_RESET;
         cfg_ff.avg_interval <= AVG_INT_RESET;
         cfg_ff.log_interval <= LOG_INT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/frm_div.sv =====
// Shared bit-serial divider with saturation of the quotient.
`default_nettype none

module frm_div #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 48,
   parameter int QUOT_W = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   output logic                   done,
   output logic [QUOT_W-1:0]      quot
);
   import frm_pkg::*;

   localparam int HI_W    = NUM_W - QUOT_W;
   localparam int CMP_W   = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int STEP_W  = $clog2(QUOT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [QUOT_W-1:0]   shift_ff, shift_in;

   logic [HI_W-1:0]     num_hi;
   logic                sat;
   logic [DEN_W:0]      trial;
   logic [DEN_W:0]      trial_diff;
   logic                fits;

   assign num_hi     = num[NUM_W-1:QUOT_W];
   // The quotient overflows its width exactly when the upper part of the
   // dividend is not below the divisor.
   assign sat        = CMP_W'(num_hi) >= CMP_W'(den);
   assign trial      = {rem_ff, shift_ff[QUOT_W-1]};
   assign fits       = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      shift_in = shift_ff;
      if (start) begin
         den_in = den;
         if (sat) begin
            shift_in = '1;
            done_in  = 1'b1;
         end else begin
            rem_in   = DEN_W'(num_hi);
            shift_in = num[QUOT_W-1:0];
            step_in  = STEP_W'(QUOT_W);
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in   = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
         shift_in = {shift_ff[QUOT_W-2:0], fits};
         step_in  = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      shift_ff <= shift_in;
   end

   assign done = done_ff;
   assign quot = shift_ff;

endmodule

`default_nettype wire
